// ===== sv/tcc_pkg.sv =====
`default_nettype none
package tcc_pkg;

  parameter int CW_DEFAULT = 16;

  // square root of a 64-bit value, one result bit per cell
  parameter int SQ_VAL_W  = 64;
  parameter int ROOT_W    = 32;
  parameter int SQ_REM_W  = 35;
  parameter int SQ_CELLS  = 32;

  parameter int OUT_DATA_W = 104;
  parameter logic [63:0] QUOT_CAP = 64'h4000_0000_0000_0000;

endpackage
`default_nettype wire

// ===== sv/triangle_circumcircle.sv =====
`default_nettype none
// Triangle circumcircle: three corners in, centre and radius out.
// Slave stream: one request per triangle, s_tdata holds ax, ay, bx, by_coord,
// cxin, cyin, COORD_WIDTH bits each, lowest first. Master stream: one result per
// request, m_tdata holds centre_x, centre_y, radius (32 bits each), then the
// degenerate and saturated flags.
// Throughput is one triangle per cycle unless m_tready stalls the pipeline. The
// pipeline has six arithmetic stages, one divider cell per numerator bit (both
// centre divisions share each cell), four stages to form the squared radius, 32
// square-root cells and the output register.
// Collinear corners give the corner average as centre, radius 0 and the
// degenerate flag.
// Reset empties the pipeline and the output register; nothing else is cleared.
// The whole pipeline advances together. While a result waits on m_tready the
// pipeline still moves as long as its last stage is empty, so requests keep
// being taken until the result at the end has nowhere to go.
module triangle_circumcircle
  import tcc_pkg::*;
#(
  parameter int COORD_WIDTH = CW_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // ax, ay, bx, by_coord, cxin, cyin
  input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // centre_x, centre_y, radius, degenerate, saturated
  output logic      [OUT_DATA_W-1:0]                  m_tdata
);

  localparam int C     = COORD_WIDTH;
  localparam int DXW   = C + 1;
  localparam int PW    = 2*C + 2;
  localparam int DETW  = 2*C + 3;
  localparam int MW    = DETW + DXW;
  localparam int NW    = MW + 1;
  localparam int DW    = 2*C + 4;
  localparam int SUMW  = C + 2;
  localparam int AN    = C + 1;
  localparam int AK    = AN + 3;
  localparam int AM    = ((1 << AK) + 2) / 3;
  localparam int PRW   = AN + AK;
  localparam int QXW   = (NW > 64) ? NW : 64;
  localparam int DSW   = 2*C + 67;
  localparam int SSW   = 67;
  localparam int LAT   = 6 + NW + 4 + SQ_CELLS;

  logic en;
  logic [LAT-1:0] v;

  assign en       = m_tready || !m_tvalid || !v[LAT-1];
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[LAT-2:0], s_tvalid};
    end
  end

  // ---------------- front arithmetic ----------------
  logic signed [C-1:0] ax, ay, bx, by_coord, cxin, cyin;
  assign ax       = s_tdata[0*C +: C];
  assign ay       = s_tdata[1*C +: C];
  assign bx       = s_tdata[2*C +: C];
  assign by_coord = s_tdata[3*C +: C];
  assign cxin     = s_tdata[4*C +: C];
  assign cyin     = s_tdata[5*C +: C];

  logic signed [DXW-1:0]  s1_dxa, s1_dya, s1_dxb, s1_dyb, s1_sax, s1_say, s1_sbx, s1_sby;
  logic signed [SUMW-1:0] s1_sumx, s1_sumy;
  logic signed [C-1:0]    s1_cx, s1_cy;

  logic signed [PW-1:0]   s2_pd1, s2_pd2, s2_pa1, s2_pa2, s2_pb1, s2_pb2;
  logic signed [DXW-1:0]  s2_dxa, s2_dya, s2_dxb, s2_dyb;
  logic [AN-1:0]          s2_mgx, s2_mgy;
  logic                   s2_ngx, s2_ngy;
  logic signed [C-1:0]    s2_cx, s2_cy;

  logic signed [DETW-1:0] s3_det, s3_sa, s3_sb;
  logic signed [DXW-1:0]  s3_dxa, s3_dya, s3_dxb, s3_dyb;
  logic [PRW-1:0]         s3_prx, s3_pry;
  logic                   s3_ngx, s3_ngy;
  logic signed [C-1:0]    s3_cx, s3_cy;

  logic signed [MW-1:0]   s4_m1, s4_m2, s4_m3, s4_m4;
  logic signed [DETW-1:0] s4_det;
  logic [31:0]            s4_avx, s4_avy;
  logic signed [C-1:0]    s4_cx, s4_cy;

  logic signed [NW-1:0]   s5_numx, s5_numy;
  logic signed [DETW-1:0] s5_det;
  logic [31:0]            s5_avx, s5_avy;
  logic signed [C-1:0]    s5_cx, s5_cy;

  logic [NW-1:0]          s6_magx, s6_magy;
  logic [DW-1:0]          s6_den;
  logic                   s6_negx, s6_negy, s6_degen;
  logic [31:0]            s6_avx, s6_avy;
  logic signed [C-1:0]    s6_cx, s6_cy;

  logic [AN-1:0]          q3x, q3y;
  logic signed [NW-1:0]   neg_numx, neg_numy;
  logic signed [DETW-1:0] abs_det;

  always_comb begin
    q3x      = s3_prx[PRW-1:AK];
    q3y      = s3_pry[PRW-1:AK];
    neg_numx = -s5_numx;
    neg_numy = -s5_numy;
    abs_det  = s5_det[DETW-1] ? -s5_det : s5_det;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dxa  <= DXW'(ax) - DXW'(cxin);
      s1_dya  <= DXW'(ay) - DXW'(cyin);
      s1_dxb  <= DXW'(bx) - DXW'(cxin);
      s1_dyb  <= DXW'(by_coord) - DXW'(cyin);
      s1_sax  <= DXW'(ax) + DXW'(cxin);
      s1_say  <= DXW'(ay) + DXW'(cyin);
      s1_sbx  <= DXW'(bx) + DXW'(cxin);
      s1_sby  <= DXW'(by_coord) + DXW'(cyin);
      s1_sumx <= SUMW'(ax) + SUMW'(bx) + SUMW'(cxin);
      s1_sumy <= SUMW'(ay) + SUMW'(by_coord) + SUMW'(cyin);
      s1_cx   <= cxin;
      s1_cy   <= cyin;

      s2_pd1 <= PW'(s1_dxa) * PW'(s1_dyb);
      s2_pd2 <= PW'(s1_dxb) * PW'(s1_dya);
      s2_pa1 <= PW'(s1_dxa) * PW'(s1_sax);
      s2_pa2 <= PW'(s1_dya) * PW'(s1_say);
      s2_pb1 <= PW'(s1_dxb) * PW'(s1_sbx);
      s2_pb2 <= PW'(s1_dyb) * PW'(s1_sby);
      s2_dxa <= s1_dxa;
      s2_dya <= s1_dya;
      s2_dxb <= s1_dxb;
      s2_dyb <= s1_dyb;
      s2_ngx <= s1_sumx[SUMW-1];
      s2_ngy <= s1_sumy[SUMW-1];
      s2_mgx <= AN'(s1_sumx[SUMW-1] ? -s1_sumx : s1_sumx);
      s2_mgy <= AN'(s1_sumy[SUMW-1] ? -s1_sumy : s1_sumy);
      s2_cx  <= s1_cx;
      s2_cy  <= s1_cy;

      s3_det <= DETW'(s2_pd1) - DETW'(s2_pd2);
      s3_sa  <= DETW'(s2_pa1) + DETW'(s2_pa2);
      s3_sb  <= DETW'(s2_pb1) + DETW'(s2_pb2);
      s3_dxa <= s2_dxa;
      s3_dya <= s2_dya;
      s3_dxb <= s2_dxb;
      s3_dyb <= s2_dyb;
      // divide by three: multiply by a rounded-up reciprocal
      s3_prx <= PRW'(s2_mgx) * PRW'(AM);
      s3_pry <= PRW'(s2_mgy) * PRW'(AM);
      s3_ngx <= s2_ngx;
      s3_ngy <= s2_ngy;
      s3_cx  <= s2_cx;
      s3_cy  <= s2_cy;

      s4_m1  <= MW'(s3_sa) * MW'(s3_dyb);
      s4_m2  <= MW'(s3_sb) * MW'(s3_dya);
      s4_m3  <= MW'(s3_sb) * MW'(s3_dxa);
      s4_m4  <= MW'(s3_sa) * MW'(s3_dxb);
      s4_det <= s3_det;
      s4_avx <= s3_ngx ? -32'(q3x) : 32'(q3x);
      s4_avy <= s3_ngy ? -32'(q3y) : 32'(q3y);
      s4_cx  <= s3_cx;
      s4_cy  <= s3_cy;

      s5_numx <= NW'(s4_m1) - NW'(s4_m2);
      s5_numy <= NW'(s4_m3) - NW'(s4_m4);
      s5_det  <= s4_det;
      s5_avx  <= s4_avx;
      s5_avy  <= s4_avy;
      s5_cx   <= s4_cx;
      s5_cy   <= s4_cy;

      s6_magx  <= s5_numx[NW-1] ? neg_numx : s5_numx;
      s6_magy  <= s5_numy[NW-1] ? neg_numy : s5_numy;
      s6_negx  <= s5_numx[NW-1] ^ s5_det[DETW-1];
      s6_negy  <= s5_numy[NW-1] ^ s5_det[DETW-1];
      s6_den   <= {abs_det, 1'b0};
      s6_degen <= s5_det == '0;
      s6_avx   <= s5_avx;
      s6_avy   <= s5_avy;
      s6_cx    <= s5_cx;
      s6_cy    <= s5_cy;
    end
  end

  // ---------------- divider chain ----------------
  logic [DW-1:0]  dv_d    [0:NW];
  logic [DW-1:0]  dv_rx   [0:NW];
  logic [DW-1:0]  dv_ry   [0:NW];
  logic [NW-1:0]  dv_nx   [0:NW];
  logic [NW-1:0]  dv_ny   [0:NW];
  logic [NW-1:0]  dv_qx   [0:NW];
  logic [NW-1:0]  dv_qy   [0:NW];
  logic [DSW-1:0] dv_side [0:NW];

  assign dv_d[0]    = s6_den;
  assign dv_rx[0]   = '0;
  assign dv_ry[0]   = '0;
  assign dv_nx[0]   = s6_magx;
  assign dv_ny[0]   = s6_magy;
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;
  assign dv_side[0] = {s6_negy, s6_negx, s6_cy, s6_cx, s6_avy, s6_avx, s6_degen};

  for (genvar i = 0; i < NW; i++) begin : g_div
    tcc_div_cell #(
      .NUM_W  (NW),
      .DEN_W  (DW),
      .SIDE_W (DSW)
    ) u_cell (
      .clk       (clk),
      .en        (en),
      .d_in      (dv_d[i]),
      .rem_x_in  (dv_rx[i]),
      .rem_y_in  (dv_ry[i]),
      .num_x_in  (dv_nx[i]),
      .num_y_in  (dv_ny[i]),
      .quo_x_in  (dv_qx[i]),
      .quo_y_in  (dv_qy[i]),
      .side_in   (dv_side[i]),
      .d_out     (dv_d[i+1]),
      .rem_x_out (dv_rx[i+1]),
      .rem_y_out (dv_ry[i+1]),
      .num_x_out (dv_nx[i+1]),
      .num_y_out (dv_ny[i+1]),
      .quo_x_out (dv_qx[i+1]),
      .quo_y_out (dv_qy[i+1]),
      .side_out  (dv_side[i+1])
    );
  end

  // ---------------- centre and squared radius ----------------
  logic           dq_degen, dq_negx, dq_negy;
  logic [31:0]    dq_avx, dq_avy;
  logic signed [C-1:0] dq_cx, dq_cy;
  logic [QXW-1:0] qex, qey;
  logic [62:0]    cap_x, cap_y;

  always_comb begin
    {dq_negy, dq_negx, dq_cy, dq_cx, dq_avy, dq_avx, dq_degen} = dv_side[NW];
    qex   = QXW'(dv_qx[NW]);
    qey   = QXW'(dv_qy[NW]);
    cap_x = (qex > QXW'(QUOT_CAP)) ? QUOT_CAP[62:0] : qex[62:0];
    cap_y = (qey > QXW'(QUOT_CAP)) ? QUOT_CAP[62:0] : qey[62:0];
  end

  logic signed [63:0]  p1_ux, p1_uy;
  logic signed [C-1:0] p1_cx, p1_cy;
  logic [31:0]         p1_avx, p1_avy;
  logic                p1_degen;

  logic signed [64:0]  dfx, dfy, ex65, ey65;
  logic [31:0]         clip_x, clip_y;
  logic                sat_x, sat_y;

  logic [31:0] p2_ex, p2_ey, p2_ox, p2_oy;
  logic        p2_big, p2_satc, p2_degen;

  logic [63:0] p3_exx, p3_eyy;
  logic [31:0] p3_ox, p3_oy;
  logic        p3_big, p3_satc, p3_degen;

  logic [64:0] s_sum;
  logic [63:0] p4_s;
  logic [31:0] p4_ox, p4_oy;
  logic        p4_radsat, p4_satc, p4_degen;

  always_comb begin
    dfx  = 65'(p1_cx) - 65'(p1_ux);
    dfy  = 65'(p1_cy) - 65'(p1_uy);
    ex65 = dfx[64] ? -dfx : dfx;
    ey65 = dfy[64] ? -dfy : dfy;
    sat_x = 1'b0;
    sat_y = 1'b0;
    clip_x = p1_ux[31:0];
    clip_y = p1_uy[31:0];
    if (p1_ux > 64'sh0000_0000_7FFF_FFFF) begin
      clip_x = 32'h7FFF_FFFF;
      sat_x  = 1'b1;
    end else if (p1_ux < -64'sh0000_0000_8000_0000) begin
      clip_x = 32'h8000_0000;
      sat_x  = 1'b1;
    end
    if (p1_uy > 64'sh0000_0000_7FFF_FFFF) begin
      clip_y = 32'h7FFF_FFFF;
      sat_y  = 1'b1;
    end else if (p1_uy < -64'sh0000_0000_8000_0000) begin
      clip_y = 32'h8000_0000;
      sat_y  = 1'b1;
    end
    s_sum = {1'b0, p3_exx} + {1'b0, p3_eyy};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ux    <= dq_negx ? -{1'b0, cap_x} : {1'b0, cap_x};
      p1_uy    <= dq_negy ? -{1'b0, cap_y} : {1'b0, cap_y};
      p1_cx    <= dq_cx;
      p1_cy    <= dq_cy;
      p1_avx   <= dq_avx;
      p1_avy   <= dq_avy;
      p1_degen <= dq_degen;

      p2_ex    <= ex65[31:0];
      p2_ey    <= ey65[31:0];
      p2_big   <= (ex65[64:32] != '0) || (ey65[64:32] != '0);
      p2_ox    <= p1_degen ? p1_avx : clip_x;
      p2_oy    <= p1_degen ? p1_avy : clip_y;
      p2_satc  <= !p1_degen && (sat_x || sat_y);
      p2_degen <= p1_degen;

      p3_exx   <= 64'(p2_ex) * 64'(p2_ex);
      p3_eyy   <= 64'(p2_ey) * 64'(p2_ey);
      p3_ox    <= p2_ox;
      p3_oy    <= p2_oy;
      p3_big   <= p2_big;
      p3_satc  <= p2_satc;
      p3_degen <= p2_degen;

      p4_s      <= s_sum[63:0];
      p4_radsat <= !p3_degen && (p3_big || s_sum[64]);
      p4_ox     <= p3_ox;
      p4_oy     <= p3_oy;
      p4_satc   <= p3_satc;
      p4_degen  <= p3_degen;
    end
  end

  // ---------------- square root chain ----------------
  logic [SQ_REM_W-1:0] sq_rem  [0:SQ_CELLS];
  logic [ROOT_W-1:0]   sq_root [0:SQ_CELLS];
  logic [SQ_VAL_W-1:0] sq_val  [0:SQ_CELLS];
  logic [SSW-1:0]      sq_side [0:SQ_CELLS];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_val[0]  = p4_s;
  assign sq_side[0] = {p4_oy, p4_ox, p4_satc, p4_radsat, p4_degen};

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    tcc_sqrt_cell #(
      .SIDE_W (SSW)
    ) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .val_in   (sq_val[k]),
      .side_in  (sq_side[k]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1]),
      .val_out  (sq_val[k+1]),
      .side_out (sq_side[k+1])
    );
  end

  // ---------------- output register ----------------
  logic [31:0] f_ox, f_oy, f_rad;
  logic        f_satc, f_radsat, f_degen;

  always_comb begin
    {f_oy, f_ox, f_satc, f_radsat, f_degen} = sq_side[SQ_CELLS];
    if (f_degen) begin
      f_rad = '0;
    end else if (f_radsat) begin
      f_rad = '1;
    end else begin
      f_rad = sq_root[SQ_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en && v[LAT-1]) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v[LAT-1]) begin
      m_tdata <= {6'b0, f_satc | f_radsat, f_degen, f_rad, f_oy, f_ox};
    end
  end

`ifndef NO_ASSERTIONS
  a_degen_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[96] |-> (m_tdata[95:64] == '0) && !m_tdata[97])
    else $error("degenerate result with nonzero radius or saturation");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

  a_last_held: assert property (@(posedge clk) disable iff (rst)
    v[LAT-1] && m_tvalid && !m_tready |=> v[LAT-1])
    else $error("pipeline end lost a request under stall");
`endif

endmodule
`default_nettype wire

// ===== sv/tcc_div_cell.sv =====
`default_nettype none
module tcc_div_cell #(
  parameter int NUM_W  = 53,
  parameter int DEN_W  = 36,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DEN_W-1:0]  d_in,
  input  wire logic [DEN_W-1:0]  rem_x_in,
  input  wire logic [DEN_W-1:0]  rem_y_in,
  input  wire logic [NUM_W-1:0]  num_x_in,
  input  wire logic [NUM_W-1:0]  num_y_in,
  input  wire logic [NUM_W-1:0]  quo_x_in,
  input  wire logic [NUM_W-1:0]  quo_y_in,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic      [DEN_W-1:0]  d_out,
  output logic      [DEN_W-1:0]  rem_x_out,
  output logic      [DEN_W-1:0]  rem_y_out,
  output logic      [NUM_W-1:0]  num_x_out,
  output logic      [NUM_W-1:0]  num_y_out,
  output logic      [NUM_W-1:0]  quo_x_out,
  output logic      [NUM_W-1:0]  quo_y_out,
  output logic      [SIDE_W-1:0] side_out
);

  logic [DEN_W:0] tx, ty, dx_diff, dy_diff, d_ext;
  logic           ge_x, ge_y;

  // restoring step: bring down one numerator bit, subtract if it fits
  always_comb begin
    d_ext   = {1'b0, d_in};
    tx      = {rem_x_in, num_x_in[NUM_W-1]};
    ty      = {rem_y_in, num_y_in[NUM_W-1]};
    ge_x    = tx >= d_ext;
    ge_y    = ty >= d_ext;
    dx_diff = tx - d_ext;
    dy_diff = ty - d_ext;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out     <= d_in;
      rem_x_out <= ge_x ? dx_diff[DEN_W-1:0] : tx[DEN_W-1:0];
      rem_y_out <= ge_y ? dy_diff[DEN_W-1:0] : ty[DEN_W-1:0];
      num_x_out <= {num_x_in[NUM_W-2:0], 1'b0};
      num_y_out <= {num_y_in[NUM_W-2:0], 1'b0};
      quo_x_out <= {quo_x_in[NUM_W-2:0], ge_x};
      quo_y_out <= {quo_y_in[NUM_W-2:0], ge_y};
      side_out  <= side_in;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcc_sqrt_cell.sv =====
`default_nettype none
module tcc_sqrt_cell
  import tcc_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [SQ_REM_W-1:0] rem_in,
  input  wire logic [ROOT_W-1:0]   root_in,
  input  wire logic [SQ_VAL_W-1:0] val_in,
  input  wire logic [SIDE_W-1:0]   side_in,
  output logic      [SQ_REM_W-1:0] rem_out,
  output logic      [ROOT_W-1:0]   root_out,
  output logic      [SQ_VAL_W-1:0] val_out,
  output logic      [SIDE_W-1:0]   side_out
);

  logic [SQ_REM_W-1:0] tx, trial;
  logic                ge;

  // two value bits in, one root bit out
  always_comb begin
    tx    = {rem_in[SQ_REM_W-3:0], val_in[SQ_VAL_W-1:SQ_VAL_W-2]};
    trial = SQ_REM_W'({root_in, 2'b01});
    ge    = tx >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? (tx - trial) : tx;
      root_out <= {root_in[ROOT_W-2:0], ge};
      val_out  <= {val_in[SQ_VAL_W-3:0], 2'b00};
      side_out <= side_in;
    end
  end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
  import tcc_pkg::*;

  localparam int CW = CW_DEFAULT;
  localparam int IN_W = ((6*CW+7)/8)*8;
  localparam int LATENCY = 3*CW + 48;
  localparam logic signed [127:0] QCAP = 128'sh4000_0000_0000_0000;
  localparam logic signed [127:0] I32_MAX = 128'sd2147483647;
  localparam logic signed [127:0] I32_MIN = -128'sd2147483648;
  localparam logic signed [127:0] U32_MAX = 128'sd4294967295;
  localparam logic signed [127:0] U64_LIM = 128'sh1_0000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] rad;
    logic        degen;
    logic        sat;
  } circle_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  circle_t circle_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic hold_off = 1'b0;
  event hold_go;

  triangle_circumcircle #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [31:0] res;
    logic [31:0] t;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      t = res | (32'd1 << i);
      if (64'(t) * 64'(t) <= v) res = t;
    end
    return res;
  endfunction

  function automatic logic signed [127:0] coord(logic [IN_W-1:0] d, int idx);
    logic [CW-1:0] f;
    f = d[idx*CW +: CW];
    return {{(128-CW){f[CW-1]}}, f};
  endfunction

  function automatic circle_t predict_circle(logic [IN_W-1:0] d);
    logic signed [127:0] ax, ay, bx, by, cx, cy, dxa, dya, dxb, dyb, det;
    logic signed [127:0] sa, sb, ux, uy, ex, ey, s;
    circle_t r;
    ax = coord(d, 0); ay = coord(d, 1); bx = coord(d, 2);
    by = coord(d, 3); cx = coord(d, 4); cy = coord(d, 5);
    dxa = ax - cx; dya = ay - cy; dxb = bx - cx; dyb = by - cy;
    det = dxa * dyb - dxb * dya;
    r = '0;
    if (det == 0) begin
      r.degen = 1'b1;
      r.cx = 32'((ax + bx + cx) / 3);
      r.cy = 32'((ay + by + cy) / 3);
      return r;
    end
    sa = dxa * (ax + cx) + dya * (ay + cy);
    sb = dxb * (bx + cx) + dyb * (by + cy);
    ux = (sa * dyb - sb * dya) / (2 * det);
    uy = (sb * dxa - sa * dxb) / (2 * det);
    if (ux > QCAP) ux = QCAP;
    if (ux < -QCAP) ux = -QCAP;
    if (uy > QCAP) uy = QCAP;
    if (uy < -QCAP) uy = -QCAP;
    // radius taken from the centre before it is clipped to 32 bits
    ex = cx - ux; if (ex < 0) ex = -ex;
    ey = cy - uy; if (ey < 0) ey = -ey;
    if (ex > U32_MAX || ey > U32_MAX) begin
      r.rad = '1; r.sat = 1'b1;
    end else begin
      s = ex * ex + ey * ey;
      if (s >= U64_LIM) begin
        r.rad = '1; r.sat = 1'b1;
      end else begin
        r.rad = floor_sqrt(s[63:0]);
      end
    end
    if (ux > I32_MAX) begin ux = I32_MAX; r.sat = 1'b1; end
    if (ux < I32_MIN) begin ux = I32_MIN; r.sat = 1'b1; end
    if (uy > I32_MAX) begin uy = I32_MAX; r.sat = 1'b1; end
    if (uy < I32_MIN) begin uy = I32_MIN; r.sat = 1'b1; end
    r.cx = ux[31:0];
    r.cy = uy[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_go);
      hold_off <= 1'b1;
      repeat (400) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // receiver: random stalls, or the hold-off
  always @(posedge clk) begin
    if (hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    circle_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (circle_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
      end else begin
        want = circle_q.pop_front();
        if (m_tdata[31:0] !== want.cx) report_mismatch("centre_x", m_tdata[31:0], want.cx);
        if (m_tdata[63:32] !== want.cy) report_mismatch("centre_y", m_tdata[63:32], want.cy);
        if (m_tdata[95:64] !== want.rad) report_mismatch("radius", m_tdata[95:64], want.rad);
        if (m_tdata[96] !== want.degen) report_mismatch("degenerate", 32'(m_tdata[96]),
                                                         32'(want.degen));
        if (m_tdata[97] !== want.sat) report_mismatch("saturated", 32'(m_tdata[97]),
                                                       32'(want.sat));
      end
    end
  end

  task automatic send_triangle(logic signed [15:0] ax, ay, bx, by, cx, cy);
    logic [IN_W-1:0] d;
    d = '0;
    d[6*CW-1:0] = {cy, cx, by, bx, ay, ax};
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    circle_q.insert(circle_q.size(), predict_circle(d));
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (circle_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic test_directed;
    send_triangle(0, 0, 0, 0, 0, 0);
    send_triangle(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_triangle(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    send_triangle(0, 0, 256, 0, 0, 256);
    send_triangle(-16'sh8000, -16'sh8000, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff);
    send_triangle(16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000);
    send_triangle(-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 0, 0);
    send_triangle(0, 0, 256, 256, 512, 512);       // collinear
    send_triangle(-100, -100, -200, -200, -301, -301);
    send_triangle(10, 20, 10, 20, 30, 40);          // repeated corner
    // almost collinear: centre far out
    send_triangle(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7ffe);
    send_triangle(-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh7ffe, -16'sh7fff);
    send_triangle(0, 0, 1, 0, 16'sh7fff, 1);
    send_triangle(-16'sh8000, 0, 16'sh7fff, 0, 0, 1);
    send_triangle(1, 1, -1, -1, 1, -1);
    send_triangle(16'sh5555, -16'sh2aab, 16'sh2aaa, 16'sh5555, -16'sh5556, 16'sh1234);
    send_triangle(-1, -1, -1, -1, -1, -2);
    send_triangle(16'sh7fff, 0, 0, 16'sh7fff, -16'sh8000, -16'sh8000);
    drain();
  endtask

  task automatic random_triangle;
    logic signed [15:0] p[6];
    logic signed [15:0] step_x, step_y;
    int kind;
    int lim;
    kind = $urandom_range(9);
    lim = ($urandom_range(3) == 0) ? 32767 : $urandom_range(2000);
    foreach (p[i]) p[i] = 16'($urandom_range(2 * lim) - lim);
    if (kind < 3) begin
      foreach (p[i]) p[i] = 16'($urandom);
    end else if (kind == 3) begin
      // collinear by equal steps
      step_x = 16'($urandom_range(200) - 100);
      step_y = 16'($urandom_range(200) - 100);
      p[2] = p[0] + step_x; p[3] = p[1] + step_y;
      p[4] = p[2] + step_x; p[5] = p[3] + step_y;
    end else if (kind == 4) begin
      p[4] = p[2] + 16'($urandom_range(2) - 1);
      p[5] = p[3] + 16'($urandom_range(2) - 1);
    end
    send_triangle(p[0], p[1], p[2], p[3], p[4], p[5]);
  endtask

  task automatic test_random(int n, int sidle, int ridle);
    send_idle = sidle;
    recv_idle = ridle;
    repeat (n) random_triangle();
    drain();
  endtask

  task automatic test_backpressure;
    send_idle = 0;
    recv_idle = 0;
    -> hold_go;
    repeat (150) random_triangle();
    drain();
    repeat (20) random_triangle();
    drain();
  endtask

  initial begin
    #(12 * 2000000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(290, 31, 66);
    test_random(290, 66, 31);
    test_random(290, 0, 0);
    test_backpressure();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tcc_pkg.sv
sv/tcc_div_cell.sv
sv/tcc_sqrt_cell.sv
sv/triangle_circumcircle.sv
bench/testbench.sv
